[src/csq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csq_pkg
// Shared codes for the counting semaphore with its wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_BLOCKED   = 3'd1,
		ST_RELEASED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef enum logic {
		CMD_DOWN = 1'b0,
		CMD_UP   = 1'b1
	} cmd_t;

	localparam int REG_INITIAL_COUNT = 0;
	localparam int CFG_DATA_BITS     = 32;
	localparam int CFG_ADDR_BITS     = 3;
	localparam int INIT_FIELD_BITS   = 16;

endpackage : csq_pkg
`default_nettype wire

[src/counting_semaphore_wait_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_top
// Counting semaphore with a FIFO queue of waiting thread identifiers.
// ----------------------------------------------------------------------------
// Each request word is registered in the s1 stage and then in the output
// register: the count, queue pointers and occupancy update at acceptance,
// while the wait queue memory is read at the head pointer, and the registered
// read data fills the result in the next cycle. A new request is not accepted
// while a word is in the s1 stage or a held result word waits for out_ready.
// Writing the initial count register loads the count at once and leaves the
// queue alone. A woken thread must issue its down request again.
module counting_semaphore_wait_queue_top
	import csq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8,
	parameter int COUNT_BITS  = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,

	input  wire                      psel,
	input  wire                      penable,
	input  wire                      pwrite,
	input  wire [CFG_ADDR_BITS-1:0]  paddr,
	input  wire [CFG_DATA_BITS-1:0]  pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,

	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      cmd,
	input  wire [ID_BITS-1:0]        thread_id,

	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [2:0]               status,
	output logic                     woken_valid,
	output logic [ID_BITS-1:0]       woken_thread,
	output logic [COUNT_BITS-1:0]    count_value
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [OCC_BITS-1:0]   OCC_FULL  = OCC_BITS'(QUEUE_DEPTH);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [ID_BITS-1:0] queue_mem [QUEUE_DEPTH];
	logic [ID_BITS-1:0] rdata_s2;

	logic [COUNT_BITS-1:0] init_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PTR_BITS-1:0]   head_q;
	logic [PTR_BITS-1:0]   tail_q;
	logic [OCC_BITS-1:0]   occ_q;

	logic                  valid_s1;
	status_t               status_s1;
	logic                  woken_s1;
	logic [COUNT_BITS-1:0] count_s1;

	status_t               status_q;
	logic                  woken_q;
	logic [COUNT_BITS-1:0] count_out_q;

	logic                  cfg_wr;
	logic [COUNT_BITS-1:0] init_val;
	logic                  in_acc;
	logic                  is_up;
	logic                  count_zero;
	logic                  q_empty;
	logic                  q_full;
	logic                  do_push;
	logic                  do_pop;
	status_t               status_d;
	logic [COUNT_BITS-1:0] count_d;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(int'(paddr[CFG_ADDR_BITS-1:2]) == REG_INITIAL_COUNT);

	always_comb begin
		for (int i = 0; i < COUNT_BITS; i++) begin
			init_val[i] = (i < INIT_FIELD_BITS) ? pwdata[i] : 1'b0;
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < COUNT_BITS && i < CFG_DATA_BITS; i++) begin
			prdata[i] = (int'(paddr[CFG_ADDR_BITS-1:2]) == REG_INITIAL_COUNT) ? init_q[i] : 1'b0;
		end
	end

	assign in_ready   = !valid_s1 && (!out_valid || out_ready);
	assign in_acc     = in_valid && in_ready;
	assign is_up      = (cmd == CMD_UP);
	assign count_zero = (count_q == '0);
	assign q_empty    = (occ_q == '0);
	assign q_full     = (occ_q == OCC_FULL);
	assign do_push    = in_acc && !is_up && count_zero && !q_full;
	assign do_pop     = in_acc && is_up && !q_empty;

	always_comb begin
		status_d = ST_GRANTED;
		count_d  = count_q;
		if (is_up) begin
			if (count_q == COUNT_MAX) begin
				status_d = ST_SATURATED;
			end else begin
				status_d = ST_RELEASED;
				count_d  = count_q + COUNT_BITS'(1);
			end
		end else if (!count_zero) begin
			status_d = ST_GRANTED;
			count_d  = count_q - COUNT_BITS'(1);
		end else if (!q_full) begin
			status_d = ST_BLOCKED;
		end else begin
			status_d = ST_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_mem[tail_q] <= thread_id;
		end
		rdata_s2 <= queue_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
		end else begin
			if (cfg_wr) begin
				init_q  <= init_val;
				count_q <= init_val;
			end else if (in_acc) begin
				count_q <= count_d;
			end
			if (do_push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_BITS'(1);
				occ_q  <= occ_q + OCC_BITS'(1);
			end else if (do_pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_BITS'(1);
				occ_q  <= occ_q - OCC_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			if (valid_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1 <= status_d;
			woken_s1  <= do_pop;
			count_s1  <= count_d;
		end
		if (valid_s1) begin
			status_q    <= status_s1;
			woken_q     <= woken_s1;
			count_out_q <= count_s1;
		end
	end

	logic [ID_BITS-1:0] woken_id_q;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			woken_id_q <= woken_s1 ? rdata_s2 : '0;
		end
	end

	assign status       = status_q;
	assign woken_valid  = woken_q;
	assign woken_thread = woken_id_q;
	assign count_value  = count_out_q;

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> out_valid)
		else $error("Pipeline word did not reach the output register.");

	a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !in_ready)
		else $error("Request accepted while a word is in flight.");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("Wait queue occupancy exceeds its depth.");

	a_woken_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && woken_valid) |->
			(status == ST_RELEASED || status == ST_SATURATED))
		else $error("Woken thread reported on a down request.");

endmodule : counting_semaphore_wait_queue_top
`default_nettype wire

[tb/sv/counting_semaphore_wait_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_top_tb
// Drives down and up request words into the semaphore and checks every result
// word against a cycle-free model of the count and the wait queue, or a table
// row's typed expectation. A short table covers the reset state, a full queue,
// saturation and a count load with waiters queued. Random phases follow with
// different initial counts, and woken threads retry their down requests.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top_tb;
	import csq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int COUNT_BITS  = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 290;
	localparam int NUM_PHASES  = 6;

	typedef struct packed {
		status_t               st;
		logic                  wv;
		logic [ID_BITS-1:0]    wt;
		logic [COUNT_BITS-1:0] cnt;
	} sem_result_t;

	typedef enum logic {
		ROW_WORD = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [31:0]        cfg_word;
		cmd_t               c;
		logic [ID_BITS-1:0] id;
		bit                 typed;
		sem_result_t        want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_ready;
	cmd_t                     cmd;
	logic [ID_BITS-1:0]       thread_id;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               status;
	logic                     woken_valid;
	logic [ID_BITS-1:0]       woken_thread;
	logic [COUNT_BITS-1:0]    count_value;

	logic [COUNT_BITS-1:0]    sem_level;
	logic [COUNT_BITS-1:0]    init_reg;
	logic [ID_BITS-1:0]       waiters [QUEUE_DEPTH];
	logic [3:0]               wq_head;
	logic [3:0]               wq_tail;
	int                       wq_fill;

	sem_result_t              pending_results [$];
	logic [ID_BITS-1:0]       retry_ids [$];
	dir_row_t                 rows [$];
	sem_result_t              head_result;
	int                       error_count;
	int                       cycle_count;
	bit                       idle_on;

	counting_semaphore_wait_queue_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.thread_id    (thread_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.woken_valid  (woken_valid),
		.woken_thread (woken_thread),
		.count_value  (count_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic sem_result_t predict_semaphore(input cmd_t c, input logic [ID_BITS-1:0] id);
		sem_result_t r;
		r = '0;
		if (c == CMD_DOWN) begin
			if (sem_level != 0) begin
				sem_level = sem_level - 1'b1;
				r.st = ST_GRANTED;
			end else if (wq_fill < QUEUE_DEPTH) begin
				waiters[wq_tail] = id;
				wq_tail = wq_tail + 1'b1;
				wq_fill++;
				r.st = ST_BLOCKED;
			end else begin
				r.st = ST_FULL;
			end
		end else begin
			if (sem_level == {COUNT_BITS{1'b1}}) begin
				r.st = ST_SATURATED;
			end else begin
				sem_level = sem_level + 1'b1;
				r.st = ST_RELEASED;
			end
			if (wq_fill != 0) begin
				r.wv = 1'b1;
				r.wt = waiters[wq_head];
				wq_head = wq_head + 1'b1;
				wq_fill--;
			end
		end
		r.cnt = sem_level;
		return r;
	endfunction

	function automatic sem_result_t outcome(input status_t st, input logic wv,
			input logic [ID_BITS-1:0] wt, input logic [COUNT_BITS-1:0] cnt);
		sem_result_t r;
		r.st  = st;
		r.wv  = wv;
		r.wt  = wt;
		r.cnt = cnt;
		return r;
	endfunction

	function automatic dir_row_t word_row(input cmd_t c, input logic [ID_BITS-1:0] id,
			input bit typed, input sem_result_t want);
		dir_row_t r;
		r.kind     = ROW_WORD;
		r.cfg_word = '0;
		r.c        = c;
		r.id       = id;
		r.typed    = typed;
		r.want     = want;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [31:0] w);
		dir_row_t r;
		r.kind     = ROW_CFG;
		r.cfg_word = w;
		r.c        = CMD_DOWN;
		r.id       = '0;
		r.typed    = 1'b0;
		r.want     = '0;
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write_initial(input logic [31:0] data);
		logic [CFG_DATA_BITS-1:0] rd;
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= CFG_ADDR_BITS'(REG_INITIAL_COUNT * 4);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		init_reg  = data[INIT_FIELD_BITS-1:0];
		sem_level = init_reg;
		if (rd !== {{(CFG_DATA_BITS-COUNT_BITS){1'b0}}, init_reg})
			note_error($sformatf("initial_count read %h, wrote %h", rd, init_reg));
	endtask

	task automatic send_word(input cmd_t c, input logic [ID_BITS-1:0] id,
			input bit typed, input sem_result_t want);
		sem_result_t pred;
		while (idle_on && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		thread_id <= id;
		do @(posedge clk); while (!in_ready);
		pred = predict_semaphore(c, id);
		if (pred.wv) begin
			retry_ids.push_back(pred.wt);
			if (retry_ids.size() > 32)
				void'(retry_ids.pop_front());
		end
		pending_results.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= !idle_on || ($urandom_range(0, 99) >= 35);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_error("result word with nothing expected");
			end else begin
				head_result = pending_results.pop_front();
				if (status !== head_result.st)
					note_error($sformatf("status %0d, expected %0d", status, head_result.st));
				if (woken_valid !== head_result.wv)
					note_error($sformatf("woken_valid %b, expected %b", woken_valid,
						head_result.wv));
				if (woken_thread !== head_result.wt)
					note_error($sformatf("woken_thread %h, expected %h", woken_thread,
						head_result.wt));
				if (count_value !== head_result.cnt)
					note_error($sformatf("count_value %h, expected %h", count_value,
						head_result.cnt));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("counting_semaphore_wait_queue_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		logic [15:0]           phase_counts [NUM_PHASES];
		logic [15:0]           junk;
		int                    down_pct;
		cmd_t                  c;
		logic [ID_BITS-1:0]    id;
		sem_result_t           none;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		cmd         = CMD_DOWN;
		thread_id   = '0;
		error_count = 0;
		cycle_count = 0;
		idle_on     = 1'b1;
		sem_level   = '0;
		init_reg    = '0;
		wq_head     = '0;
		wq_tail     = '0;
		wq_fill     = 0;
		none        = '0;
		down_pct    = 50;

		phase_counts = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h0000, 16'h0002};
		phase_counts[4] = 16'($urandom_range(0, 65535));

		rows.push_back(word_row(CMD_UP, 8'h00, 1'b1, outcome(ST_RELEASED, 1'b0, 8'h00, 16'd1)));
		rows.push_back(word_row(CMD_DOWN, 8'hFF, 1'b1, outcome(ST_GRANTED, 1'b0, 8'h00, 16'd0)));
		for (int i = 0; i < QUEUE_DEPTH; i++)
			rows.push_back(word_row(CMD_DOWN, 8'(255 - 17 * i), 1'b1,
				outcome(ST_BLOCKED, 1'b0, 8'h00, 16'd0)));
		rows.push_back(word_row(CMD_DOWN, 8'h5A, 1'b1, outcome(ST_FULL, 1'b0, 8'h00, 16'd0)));
		rows.push_back(cfg_row(32'hA5A5_FFFF));
		rows.push_back(word_row(CMD_UP, 8'h00, 1'b1,
			outcome(ST_SATURATED, 1'b1, 8'hFF, 16'hFFFF)));
		rows.push_back(word_row(CMD_DOWN, 8'hFF, 1'b1,
			outcome(ST_GRANTED, 1'b0, 8'h00, 16'hFFFE)));
		rows.push_back(word_row(CMD_UP, 8'hEE, 1'b0, none));
		rows.push_back(word_row(CMD_UP, 8'h00, 1'b0, none));
		rows.push_back(cfg_row(32'h0000_0000));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				in_valid <= 1'b0;
				wait_drained();
				apb_write_initial(rows[i].cfg_word);
			end else begin
				send_word(rows[i].c, rows[i].id, rows[i].typed, rows[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			in_valid <= 1'b0;
			wait_drained();
			idle_on = (ph != 3);
			junk = 16'($urandom);
			apb_write_initial({junk, phase_counts[ph]});
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 32 == 0)
					case ($urandom_range(0, 2))
						0: down_pct = 15;
						1: down_pct = 50;
						default: down_pct = 85;
					endcase
				c = ($urandom_range(0, 99) < down_pct) ? CMD_DOWN : CMD_UP;
				if (c == CMD_DOWN && retry_ids.size() != 0 && $urandom_range(0, 99) < 70)
					id = retry_ids.pop_front();
				else
					id = ID_BITS'($urandom);
				send_word(c, id, 1'b0, none);
			end
		end

		in_valid <= 1'b0;
		idle_on = 1'b1;
		wait_drained();
		repeat (6) @(posedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d result words never arrived", pending_results.size()));
		if (error_count == 0)
			$display("counting_semaphore_wait_queue_top_tb: done, clean");
		else
			$display("counting_semaphore_wait_queue_top_tb: done, errors");
		$finish;
	end

endmodule
